@@ rtl/core/assert_macros.svh @@
// Assertion helpers included by the predictor core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond implies prop at the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Check that cond implies prop at the following edge.
`define ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

@@ rtl/core/pbpt_pkg.sv @@
package pbpt_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int SCAN_W        = IDX_W + 1;

  localparam int PC_W    = 64;
  localparam int SLOT_W  = 10;
  localparam int CNT_W   = 6;
  localparam int USERS_W = 16;
  localparam int SEL_W   = 10;
  localparam int KIND_W  = 3;
  localparam int MODE_W  = 2;

  localparam logic [SEL_W-1:0]   SEL_RESET = SEL_W'(512);
  localparam logic [SEL_W-1:0]   SEL_MAX   = SEL_W'((1 << SEL_W) - 1);
  localparam logic [CNT_W-1:0]   CNT_INIT  = CNT_W'((1 << (CNT_W - 1)) - 1);
  localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'((1 << CNT_W) - 1);
  localparam logic [USERS_W-1:0] USERS_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_QUERY = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MISS  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HIT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EVICT = 3'd4;

  localparam logic [MODE_W-1:0] MODE_LRU    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DYN    = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [PC_W-1:0]    pc;
    logic               pol;
    logic [CNT_W-1:0]   cnt;
    logic [USERS_W-1:0] users;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic             cmp_vld;
    logic [IDX_W-1:0] idx;
    logic [PC_W-1:0]  key;
    logic             dp;
  } match_ctl_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   match_idx;
    logic [CNT_W-1:0]   match_cnt;
    logic [USERS_W-1:0] match_users;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
  } match_res_t;

endpackage

@@ rtl/core/pbpt_ram.sv @@
module pbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/pbpt_match.sv @@
module pbpt_match import pbpt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  match_ctl_t ctl,
  input  entry_t     entry,
  output match_res_t res
);

  logic hit;

  // First valid entry with the same key, default policy and live users.
  assign hit = entry.valid && (entry.pc == ctl.key) && (entry.pol == ctl.dp)
               && (entry.users != '0);

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      res.found      <= 1'b0;
      res.free_found <= 1'b0;
    end else if (ctl.cmp_vld) begin
      if (hit && !res.found) begin
        res.found <= 1'b1;
      end
      if (!entry.valid) begin
        res.free_found <= 1'b1;
      end
    end
    // Payload: keep the first match, overwrite the free index to end on the highest.
    if (ctl.cmp_vld) begin
      if (hit && !res.found) begin
        res.match_idx   <= ctl.idx;
        res.match_cnt   <= entry.cnt;
        res.match_users <= entry.users;
      end
      if (!entry.valid) begin
        res.free_idx <= ctl.idx;
      end
    end
  end

endmodule

@@ rtl/core/pc_bypass_predictor_table_core.sv @@
// PC-keyed cache insertion predictor (LRU insert or bypass) with a global selector.
// Requests enter on the s_ channel: tuser carries the event kind, tdata the PC,
// table slot and reuse flag. Each request yields exactly one result on the m_
// channel: policy and found_slot in tdata, slot_ok in tuser.
// Query, allocate and miss feedback scan every table entry through one compare
// unit, one entry per cycle from the single table RAM read port.
// Hit and evict take one read-modify-write of the entry at their slot. Events
// made inert by a forced mode, miss feedback with a zero PC, and unknown kinds
// go straight to the result.
// One request is in work at a time; s_tready is high only while idle.
// The result waits in an output register, so a new request is accepted while
// an earlier result is still stalled; the block then holds the finished result
// internally until the output register frees.
// After reset the block sweeps the table clearing every valid bit, one entry a
// cycle, and accepts no request meanwhile; override_mode resets to dynamic
// prediction and the selector to its midpoint.
// cfg_we writes override_mode at any time; write it only while idle.
`include "assert_macros.svh"

module pc_bypass_predictor_table_core import pbpt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,  // override_mode
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,    // [63:0] pc, [73:64] slot, [74] reuse, [79:75] zero
  input  logic [2:0]  s_tuser,    // [2:0] kind
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // [0] policy, [10:1] found_slot, [15:11] zero
  output logic [0:0]  m_tuser     // [0] slot_ok
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_APPLY = 3'd3;
  localparam logic [2:0] ST_RMW   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  logic [2:0]        state;
  logic [MODE_W-1:0] override_mode;
  logic [SEL_W-1:0]  sel;
  logic [IDX_W-1:0]  clr_idx;
  logic [SCAN_W-1:0] scan_idx;
  logic              cmp_vld;
  logic [IDX_W-1:0]  cmp_idx;

  // latched request
  logic [KIND_W-1:0] kind;
  logic [PC_W-1:0]   pc;
  logic [SLOT_W-1:0] slot;
  logic              reuse;
  logic              dp;

  // pending result
  logic              res_policy;
  logic [SLOT_W-1:0] res_found;
  logic              res_ok;

  // incoming fields
  logic [PC_W-1:0]   in_pc;
  logic [SLOT_W-1:0] in_slot;
  logic              in_reuse;
  logic [KIND_W-1:0] in_kind;
  logic              accept;
  logic              fixed;
  logic              in_range;
  logic              scan_end;

  // table RAM ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  match_ctl_t mctl;
  match_res_t mres;

  logic [USERS_W-1:0] users_dec;

  assign in_pc    = s_tdata[63:0];
  assign in_slot  = s_tdata[73:64];
  assign in_reuse = s_tdata[74];
  assign in_kind  = s_tuser;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign fixed    = (override_mode == MODE_LRU) || (override_mode == MODE_BYPASS);
  assign in_range = (32'(in_slot) < TABLE_ENTRIES);
  assign scan_end = (scan_idx == SCAN_END);

  // Read address: the request's slot on acceptance, the sweep index while scanning.
  assign ram_raddr = (state == ST_SCAN) ? scan_idx[IDX_W-1:0] : IDX_W'(in_slot);

  pbpt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mctl.start   = accept;
  assign mctl.cmp_vld = cmp_vld;
  assign mctl.idx     = cmp_idx;
  assign mctl.key     = pc;
  assign mctl.dp      = dp;

  pbpt_match u_match (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mctl),
    .entry (ram_rdata),
    .res   (mres)
  );

  assign users_dec = (ram_rdata.users != '0) ? ram_rdata.users - 1'b1 : '0;

  // Table write port: clearing sweep, allocate, and hit/evict training.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_APPLY: begin
        if (kind == KIND_ALLOC) begin
          ram_wdata.valid = 1'b1;
          ram_wdata.pc    = pc;
          ram_wdata.pol   = dp;
          if (mres.found) begin
            // Merge: bump the user count, saturating.
            ram_we          = 1'b1;
            ram_waddr       = mres.match_idx;
            ram_wdata.cnt   = mres.match_cnt;
            ram_wdata.users = (mres.match_users != USERS_MAX) ?
                              mres.match_users + 1'b1 : mres.match_users;
          end else if (mres.free_found) begin
            ram_we          = 1'b1;
            ram_waddr       = mres.free_idx;
            ram_wdata.cnt   = CNT_INIT;
            ram_wdata.users = USERS_W'(1);
          end
        end
      end
      ST_RMW: begin
        ram_waddr = IDX_W'(slot);
        ram_wdata = ram_rdata;
        if (kind == KIND_HIT) begin
          if (ram_rdata.valid && ram_rdata.cnt != '0) begin
            ram_we        = 1'b1;
            ram_wdata.cnt = ram_rdata.cnt - 1'b1;
          end
        end else if (ram_rdata.valid) begin
          // Evict: drop a user; free the entry at zero, else train on no reuse.
          ram_we          = 1'b1;
          ram_wdata.users = users_dec;
          if (users_dec == '0) begin
            ram_wdata.valid = 1'b0;
          end else if (!reuse && ram_rdata.cnt != CNT_MAX) begin
            ram_wdata.cnt = ram_rdata.cnt + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      override_mode <= MODE_DYN;
    end else if (cfg_we) begin
      override_mode <= cfg_wdata;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      scan_idx <= '0;
      cmp_vld  <= 1'b0;
      sel      <= SEL_RESET;
      m_tvalid <= 1'b0;
    end else begin
      cmp_vld <= (state == ST_SCAN) && !scan_end;
      // Load the output register from the finished result, else drop it once taken.
      if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            scan_idx <= '0;
            if (!fixed && ((in_kind == KIND_QUERY) || (in_kind == KIND_ALLOC) ||
                           ((in_kind == KIND_MISS) && (in_pc != '0)))) begin
              state <= ST_SCAN;
            end else if (!fixed && in_range &&
                         ((in_kind == KIND_HIT) || (in_kind == KIND_EVICT))) begin
              state <= ST_RMW;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          // Advance one entry a cycle; the last compare lands on the end cycle.
          if (scan_end) begin
            state <= ST_APPLY;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_APPLY: begin
          if (kind == KIND_MISS && mres.found) begin
            // Move the selector away from the policy the entry predicts.
            if (mres.match_cnt[CNT_W-1]) begin
              if (sel != '0) begin
                sel <= sel - 1'b1;
              end
            end else if (sel != SEL_MAX) begin
              sel <= sel + 1'b1;
            end
          end
          state <= ST_DONE;
        end
        ST_RMW: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          // Hold the result until the output register frees.
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request latch, pending result and output payload.
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx[IDX_W-1:0];
    if (accept) begin
      kind       <= in_kind;
      pc         <= in_pc;
      slot       <= in_slot;
      reuse      <= in_reuse;
      dp         <= sel[SEL_W-1];
      res_policy <= (in_kind == KIND_QUERY) && fixed && override_mode[0];
      res_found  <= '0;
      res_ok     <= 1'b0;
    end
    if (state == ST_APPLY) begin
      if (kind == KIND_QUERY) begin
        res_policy <= mres.found ? mres.match_cnt[CNT_W-1] : dp;
      end else if (kind == KIND_ALLOC) begin
        if (mres.found) begin
          res_found <= SLOT_W'(mres.match_idx);
          res_ok    <= 1'b1;
        end else if (mres.free_found) begin
          res_found <= SLOT_W'(mres.free_idx);
          res_ok    <= 1'b1;
        end
      end
    end
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {5'b0, res_found, res_policy};
      m_tuser <= res_ok;
    end
  end

  `ASSERT_NEXT(a_one_in_work, clk, rst, accept, !s_tready, "request accepted while busy")

  `ASSERT_IMPLIES(a_write_phase, clk, rst, ram_we,
    (state == ST_CLEAR) || (state == ST_APPLY) || (state == ST_RMW),
    "table written outside a write phase")

  `ASSERT_IMPLIES(a_alloc_writes, clk, rst,
    (state == ST_APPLY) && (kind == KIND_ALLOC) && (mres.found || mres.free_found),
    ram_we, "allocate with a slot left the table unwritten")

endmodule

@@ tb/pc_bypass_predictor_table_core_test.sv @@
module pc_bypass_predictor_table_core_test;
  import pbpt_pkg::*;

  // Override mode 3 is outside the documented range; the block must treat it
  // as dynamic prediction.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int RANDOM_ITEMS   = 510;
  localparam int PC_POOL        = 8;
  localparam int WATCHDOG_LIMIT = 5000;  // a full scan plus both stalls, several times over
  localparam int DRAIN_CYCLES   = 1100;  // one table scan and a little more
  localparam int MAX_PRINTS     = 100;

  localparam logic [PC_W-1:0] PC_A = 64'hDEAD_0000_BEEF_0042;
  localparam logic [PC_W-1:0] PC_B = '1;
  localparam logic [PC_W-1:0] PC_C = 64'h0000_0000_0000_1000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PC_W-1:0]   pc;
    logic [SLOT_W-1:0] slot;
    logic              reuse;
  } request_t;

  typedef struct packed {
    logic              policy;
    logic [SLOT_W-1:0] found_slot;
    logic              slot_ok;
  } answer_t;

  // Scoreboard: keeps its own copy of the selector and the table, works out
  // the answer to every accepted request and holds the answers still owed.
  class policy_checker;
    logic [MODE_W-1:0]  mode;
    logic [SEL_W-1:0]   selector;
    bit                 live [TABLE_ENTRIES];
    logic [PC_W-1:0]    tag_pc [TABLE_ENTRIES];
    logic               tag_pol [TABLE_ENTRIES];
    logic [CNT_W-1:0]   reuse_cnt [TABLE_ENTRIES];
    logic [USERS_W-1:0] users [TABLE_ENTRIES];
    answer_t            owed[$];
    int errors, requests, results;
    int merges, fresh, refused, cnt_floor, cnt_ceiling, modes_seen;
    int sel_lo, sel_hi;

    function new();
      mode     = MODE_DYN;
      selector = SEL_RESET;
      sel_lo   = SEL_RESET;
      sel_hi   = SEL_RESET;
      foreach (live[i]) live[i] = 1'b0;
    endfunction

    function void set_mode(logic [MODE_W-1:0] m);
      mode = m;
      modes_seen++;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function logic default_pol();
      return selector[SEL_W-1];
    endfunction

    // First live entry in index order with this PC, the current default
    // policy and at least one user.
    function int find_entry(logic [PC_W-1:0] key);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (live[i]) begin
          if (tag_pc[i] == key && tag_pol[i] == default_pol() && users[i] != '0)
            return i;
        end
      end
      return -1;
    endfunction

    function answer_t predict_answer(request_t r);
      answer_t a;
      int m;
      int spare;
      bit fixed;
      a = '0;
      fixed = (mode == MODE_LRU) || (mode == MODE_BYPASS);
      case (r.kind)
        KIND_QUERY: begin
          if (fixed) begin
            a.policy = (mode == MODE_BYPASS);
          end else begin
            m = find_entry(r.pc);
            a.policy = (m >= 0) ? reuse_cnt[m][CNT_W-1] : default_pol();
          end
        end
        KIND_ALLOC: begin
          if (!fixed) begin
            m = find_entry(r.pc);
            if (m >= 0) begin
              if (users[m] != USERS_MAX) users[m]++;
              a.found_slot = SLOT_W'(m);
              a.slot_ok = 1'b1;
              merges++;
            end else begin
              spare = -1;
              for (int i = TABLE_ENTRIES - 1; i >= 0 && spare < 0; i--)
                if (!live[i]) spare = i;
              if (spare >= 0) begin
                live[spare]      = 1'b1;
                tag_pc[spare]    = r.pc;
                tag_pol[spare]   = default_pol();
                reuse_cnt[spare] = CNT_INIT;
                users[spare]     = USERS_W'(1);
                a.found_slot = SLOT_W'(spare);
                a.slot_ok = 1'b1;
                fresh++;
              end else begin
                refused++;
              end
            end
          end
        end
        KIND_MISS: begin
          if (!fixed && r.pc != '0) begin
            m = find_entry(r.pc);
            if (m >= 0) begin
              if (reuse_cnt[m][CNT_W-1]) begin
                if (selector != '0) selector--;
              end else if (selector != SEL_MAX) begin
                selector++;
              end
              if (selector < sel_lo) sel_lo = selector;
              if (selector > sel_hi) sel_hi = selector;
            end
          end
        end
        KIND_HIT: begin
          if (!fixed && live[r.slot]) begin
            if (reuse_cnt[r.slot] != '0) reuse_cnt[r.slot]--;
            else cnt_floor++;
          end
        end
        KIND_EVICT: begin
          if (!fixed && live[r.slot]) begin
            if (users[r.slot] != '0) users[r.slot]--;
            if (users[r.slot] == '0) begin
              live[r.slot] = 1'b0;
            end else if (!r.reuse) begin
              if (reuse_cnt[r.slot] != CNT_MAX) reuse_cnt[r.slot]++;
              else cnt_ceiling++;
            end
          end
        end
        default: ;
      endcase
      return a;
    endfunction

    function void note_request(request_t r);
      requests++;
      owed.push_back(predict_answer(r));
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("ERROR result %0d: %s", results, msg);
    endtask

    task check_answer(logic [15:0] data, logic [0:0] user);
      answer_t want;
      results++;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("result with none owed, tdata=%h tuser=%b", data, user));
        return;
      end
      want = owed.pop_front();
      if (data[0] !== want.policy || data[10:1] !== want.found_slot ||
          user[0] !== want.slot_ok)
        report_mismatch($sformatf(
          "got policy=%b slot=%0d ok=%b, want policy=%b slot=%0d ok=%b",
          data[0], data[10:1], user[0], want.policy, want.found_slot, want.slot_ok));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;   // [63:0] pc, [73:64] slot, [74] reuse, [79:75] zero
  logic [2:0]  s_tuser;   // [2:0] kind
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [0] policy, [10:1] found_slot, [15:11] zero
  logic [0:0]  m_tuser;   // [0] slot_ok

  policy_checker   sb = new();
  bit              steady = 1'b0;   // when set, neither side idles
  logic [PC_W-1:0] pc_pool [PC_POOL];
  int              stalled_cycles = 0;

  pc_bypass_predictor_table_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one request after a random gap and hold it until the block takes
  // it. Entered just after a rising edge; a zero gap keeps tvalid high so
  // back-to-back requests never drop the valid in between.
  task automatic send_request(logic [KIND_W-1:0] kind, logic [PC_W-1:0] pc,
                              logic [SLOT_W-1:0] slot, logic reuse);
    int gap;
    request_t r;
    gap = steady ? 0 : $urandom_range(0, 10);
    r.kind  = kind;
    r.pc    = pc;
    r.slot  = slot;
    r.reuse = reuse;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'b0, reuse, slot, pc};
    do @(posedge clk); while (s_tready !== 1'b1);
    // Note the request here, in the sending process, so that the owed
    // answer exists before anything can look at the queue.
    sb.note_request(r);
  endtask

  // Mostly well-formed traffic on a small PC pool and on the slots near the
  // top of the table, where allocation lands; a fifth of the slots and a
  // tenth of the PCs are pure noise.
  task automatic send_random();
    int pick;
    logic [KIND_W-1:0] kind;
    logic [PC_W-1:0]   pc;
    logic [SLOT_W-1:0] slot;
    pick = $urandom_range(0, 99);
    pc = pc_pool[$urandom_range(0, PC_POOL - 1)];
    if ($urandom_range(0, 9) == 0) pc = {$urandom, $urandom};
    if ($urandom_range(0, 4) == 0) slot = SLOT_W'($urandom);
    else slot = SLOT_W'(TABLE_ENTRIES - 1 - $urandom_range(0, 23));
    if (pick < 18)      kind = KIND_QUERY;
    else if (pick < 40) kind = KIND_ALLOC;
    else if (pick < 58) kind = KIND_MISS;
    else if (pick < 74) kind = KIND_HIT;
    else if (pick < 94) kind = KIND_EVICT;
    else                kind = KIND_EVICT + KIND_W'($urandom_range(1, 3));
    send_request(kind, pc, slot, 1'($urandom));
  endtask

  // Drop the request valid, wait until every owed answer is back, let the
  // block settle, then write override_mode.
  task automatic write_mode(logic [MODE_W-1:0] m);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_mode(m);
  endtask

  // Result side: unless steady, stall for a random number of cycles, then take one result.
  initial begin : result_sink
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      sb.check_answer(m_tdata, m_tuser);
    end
  end

  // Watchdog: count edges with no handshake on either channel. The reset
  // sweep and a full scan both fit well inside the limit.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stalled_cycles = 0;
    else stalled_cycles++;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d answers owed",
               stalled_cycles, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int dyn_done;
    int seg;
    int seg_len;
    bit fixed;
    logic [MODE_W-1:0] seg_mode;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= MODE_DYN;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= KIND_QUERY;
    pc_pool[0] = '0;
    pc_pool[1] = '1;
    for (int i = 2; i < PC_POOL; i++) pc_pool[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, dynamic mode from reset (selector at midpoint, so the
    // default is bypass). The block clears its table first; the first send
    // simply waits for tready.
    send_request(KIND_QUERY, PC_A, '0, 1'b0);   // no entry: default policy
    send_request(KIND_ALLOC, PC_A, '0, 1'b0);   // new entry at the top slot
    send_request(KIND_ALLOC, PC_A, '0, 1'b0);   // merge, two users
    send_request(KIND_ALLOC, PC_A, '0, 1'b0);   // merge, three users
    send_request(KIND_ALLOC, PC_B, '0, 1'b0);   // all-ones PC
    send_request(KIND_ALLOC, '0, '1, 1'b1);     // zero PC still allocates
    send_request(KIND_QUERY, PC_A, '0, 1'b0);   // counter at its initial value
    send_request(KIND_HIT, PC_B, SLOT_W'(TABLE_ENTRIES - 2), 1'b0);
    send_request(KIND_HIT, '0, '0, 1'b0);       // hit on a free entry: ignored
    send_request(KIND_EVICT, '0, '1, 1'b0);     // users stay, counter crosses half
    send_request(KIND_QUERY, PC_A, '0, 1'b0);   // entry now predicts bypass
    send_request(KIND_MISS, PC_A, '0, 1'b0);    // selector falls, default flips
    send_request(KIND_QUERY, PC_A, '0, 1'b0);   // old entry keyed to the other policy
    send_request(KIND_ALLOC, PC_A, '0, 1'b0);   // second entry, same PC, new policy
    send_request(KIND_MISS, '0, '0, 1'b0);      // zero PC: ignored
    send_request(KIND_MISS, PC_C, '0, 1'b0);    // no entry: ignored
    send_request(KIND_MISS, PC_A, '0, 1'b0);    // selector back up
    send_request(KIND_EVICT, '0, SLOT_W'(TABLE_ENTRIES - 3), 1'b1);  // last user: free
    send_request(KIND_ALLOC, PC_C, '0, 1'b0);   // refills the freed slot
    send_request(KIND_EVICT, '1, '1, 1'b1);     // reuse set: counter untouched
    send_request(KIND_EVICT, '0, SLOT_W'(5), 1'b0);  // free entry: ignored
    send_request(KIND_EVICT + KIND_W'(1), '1, '1, 1'b1);  // unknown kinds answer zero
    send_request(KIND_EVICT + KIND_W'(2), '1, '1, 1'b1);
    send_request(KIND_EVICT + KIND_W'(3), PC_A, '0, 1'b0);
    send_request(KIND_QUERY, PC_B, '0, 1'b0);

    // Random part in segments. Each segment drains the block and rewrites
    // override_mode; the first three cover both forced modes and the spare
    // encoding, later ones are mostly dynamic.
    dyn_done = 0;
    seg = 0;
    while (dyn_done < RANDOM_ITEMS) begin
      case (seg)
        0: seg_mode = MODE_LRU;
        1: seg_mode = MODE_BYPASS;
        2: seg_mode = MODE_SPARE;
        default: begin
          case ($urandom_range(0, 9))
            0:       seg_mode = MODE_LRU;
            1:       seg_mode = MODE_BYPASS;
            2:       seg_mode = MODE_SPARE;
            default: seg_mode = MODE_DYN;
          endcase
        end
      endcase
      write_mode(seg_mode);
      fixed = (seg_mode == MODE_LRU) || (seg_mode == MODE_BYPASS);
      steady = ($urandom_range(0, 3) == 0);
      pc_pool[$urandom_range(2, PC_POOL - 1)] = {$urandom, $urandom};
      seg_len = fixed ? 6 : $urandom_range(30, 70);
      repeat (seg_len) begin
        send_random();
        if (!fixed) dyn_done++;
      end
      seg++;
    end

    // Drain, then keep the result side open for one more scan so that a
    // stray result is still caught.
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests over %0d mode settings: %0d merges, %0d new entries, %0d refused",
             sb.requests, sb.modes_seen, sb.merges, sb.fresh, sb.refused);
    $display("Selector spanned %0d..%0d; counters held at floor %0d and ceiling %0d times",
             sb.sel_lo, sb.sel_hi, sb.cnt_floor, sb.cnt_ceiling);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
